// ===== rtl/core/bgfr_pkg.sv =====
// Shared constants for the glyph framebuffer renderer.
`timescale 1ns / 1ps

package bgfr_pkg;

	localparam int FONT_BYTES_DEF  = 8192;
	localparam int MAP_ENTRIES_DEF = 512;
	localparam int MAX_HEIGHT_DEF  = 16;

	localparam logic [1:0] CMD_DRAW = 2'd0;
	localparam logic [1:0] CMD_FONT = 2'd1;
	localparam logic [1:0] CMD_MAP  = 2'd2;

	localparam logic [2:0] REG_FB_BASE     = 3'd0;
	localparam logic [2:0] REG_ROW_PITCH   = 3'd1;
	localparam logic [2:0] REG_GLYPH_W     = 3'd2;
	localparam logic [2:0] REG_GLYPH_H     = 3'd3;
	localparam logic [2:0] REG_BYTES_GLYPH = 3'd4;
	localparam logic [2:0] REG_GLYPH_COUNT = 3'd5;
	localparam logic [2:0] REG_MAP_ENABLE  = 3'd6;

	localparam logic [31:0] RST_FB_BASE     = 32'd0;
	localparam logic [15:0] RST_ROW_PITCH   = 16'd4096;
	localparam logic [3:0]  RST_GLYPH_W     = 4'd8;
	localparam logic [4:0]  RST_GLYPH_H     = 5'd16;
	localparam logic [4:0]  RST_BYTES_GLYPH = 5'd16;
	localparam logic [9:0]  RST_GLYPH_COUNT = 10'd256;

endpackage

// ===== rtl/core/bitmap_glyph_framebuffer_renderer_core.sv =====
// Top level: glyph renderer with font and code map stores and a shared multiplier.
// Load items are taken in idle and write their store directly. A draw item runs the setup
// states (code map read when enabled, glyph select, multiplies), font address reduction,
// then per glyph row a fetch state and ceil(W/2) pairs; the next item is taken once the
// character's last pair has been produced.
// Async reset clears control and configuration; font and map stores are not cleared.
`timescale 1ns / 1ps

module bitmap_glyph_framebuffer_renderer_core
	import bgfr_pkg::*;
#(
	parameter int FONT_BYTES  = FONT_BYTES_DEF,
	parameter int MAP_ENTRIES = MAP_ENTRIES_DEF,
	parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] char_code,
	input  logic [7:0]  cell_x,
	input  logic [7:0]  cell_y,
	input  logic [31:0] fg_color,
	input  logic [31:0] bg_color,
	input  logic [12:0] load_index,
	input  logic [15:0] load_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pixel_address,
	output logic [31:0] first_color,
	output logic [31:0] second_color,
	output logic        second_valid,
	output logic        last_in_char,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int FAW = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;
	localparam int MAW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
	// glyph*bytes_per_glyph stays below 2^15; largest shift of FONT_BYTES the reduction subtracts
	localparam int MOD_K = ($clog2(FONT_BYTES) >= 15) ? 0 : 15 - $clog2(FONT_BYTES);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MAP  = 4'd1;
	localparam logic [3:0] ST_GLY  = 4'd2;
	localparam logic [3:0] ST_M1   = 4'd3;
	localparam logic [3:0] ST_M2   = 4'd4;
	localparam logic [3:0] ST_M3   = 4'd5;
	localparam logic [3:0] ST_M4   = 4'd6;
	localparam logic [3:0] ST_M5   = 4'd7;
	localparam logic [3:0] ST_M6   = 4'd8;
	localparam logic [3:0] ST_MOD  = 4'd9;
	localparam logic [3:0] ST_WAIT = 4'd10;
	localparam logic [3:0] ST_EMIT = 4'd11;

	logic [31:0] fb_base_q;
	logic [15:0] row_pitch_q;
	logic [3:0]  glyph_w_q;
	logic [4:0]  glyph_h_q;
	logic [4:0]  bytes_glyph_q;
	logic [9:0]  glyph_count_q;
	logic        map_en_q;

	logic [3:0]  state_q;
	logic [3:0]  k_q;
	logic [2:0]  x_q;
	logic [4:0]  y_q;
	logic        out_valid_q;

	logic [15:0] code_q;
	logic [7:0]  cx_q;
	logic [7:0]  cy_q;
	logic [31:0] fg_q;
	logic [31:0] bg_q;
	logic [9:0]  glyph_q;
	logic [31:0] mul_q;
	logic [14:0] base_q;
	logic [31:0] offs_q;
	logic [31:0] line_q;
	logic [31:0] pix_q;
	logic [FAW-1:0] faddr_q;
	logic [31:0] addr_q;
	logic [31:0] first_q;
	logic [31:0] second_q;
	logic        second_valid_q;
	logic        last_q;

	logic [7:0]  font_mem [FONT_BYTES];
	logic [15:0] map_mem [MAP_ENTRIES];
	logic [7:0]  font_rd_q;
	logic [15:0] map_rd_q;

	logic [3:0]  w;
	logic [4:0]  h;
	logic        in_xfer;
	logic        draw_go;
	logic        gen;
	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [15:0] code_eff;
	logic [9:0]  glyph_sel;
	logic [30:0] mod_wide;
	logic [30:0] mod_sub;
	logic [30:0] mod_res;
	logic        bit_a;
	logic        bit_b;
	logic        sec_ok;
	logic        row_end;
	logic        char_end;
	logic [31:0] next_line;
	logic [FAW-1:0] faddr_next;

	assign w = (glyph_w_q > 4'd8) ? 4'd8 : glyph_w_q;
	assign h = (6'(glyph_h_q) > 6'(MAX_HEIGHT)) ? 5'(MAX_HEIGHT) : glyph_h_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign draw_go   = in_xfer && (command == CMD_DRAW) && (w != 4'd0) && (h != 5'd0);
	assign gen       = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// shared multiplier operand select
	always_comb begin
		mul_a = 16'd0;
		mul_b = 16'd0;
		case (state_q)
			ST_M1: begin
				mul_a = 16'(glyph_q);
				mul_b = 16'(bytes_glyph_q);
			end
			ST_M2: begin
				mul_a = 16'(cy_q);
				mul_b = 16'(h);
			end
			ST_M3: begin
				mul_a = mul_q[15:0];
				mul_b = row_pitch_q;
			end
			ST_M4: begin
				mul_a = 16'(cx_q);
				mul_b = 16'(5'(w) + 5'd1);
			end
			default: begin
				mul_a = 16'd0;
				mul_b = 16'd0;
			end
		endcase
	end

	always_comb begin
		if (map_en_q) begin
			code_eff = (17'(code_q) < 17'(MAP_ENTRIES)) ? map_rd_q : 16'd0;
		end else begin
			code_eff = code_q;
		end
		glyph_sel = ((code_eff != 16'd0) && (code_eff < 16'(glyph_count_q))) ?
			code_eff[9:0] : 10'd0;
	end

	assign mod_wide = 31'(base_q);
	assign mod_sub  = 31'(FONT_BYTES) << k_q;
	assign mod_res  = (mod_wide >= mod_sub) ? (mod_wide - mod_sub) : mod_wide;

	assign bit_a    = font_rd_q[3'd7 - x_q];
	assign bit_b    = font_rd_q[3'd6 - x_q];
	assign sec_ok   = (4'(x_q) + 4'd1) < w;
	assign row_end  = (4'(x_q) + 4'd2) >= w;
	assign char_end = row_end && ((y_q + 5'd1) == h);
	assign next_line  = line_q + 32'(row_pitch_q);
	assign faddr_next = (faddr_q == FAW'(FONT_BYTES - 1)) ? '0 : faddr_q + FAW'(1);

	// stores
	always_ff @(posedge clk) begin
		if (in_xfer && (command == CMD_FONT) && (17'(load_index) < 17'(FONT_BYTES))) begin
			font_mem[FAW'(load_index)] <= load_data[7:0];
		end
		font_rd_q <= font_mem[faddr_q];
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (command == CMD_MAP) && (17'(load_index) < 17'(MAP_ENTRIES))) begin
			map_mem[MAW'(load_index)] <= load_data;
		end
		map_rd_q <= map_mem[MAW'(code_q)];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_base_q     <= RST_FB_BASE;
			row_pitch_q   <= RST_ROW_PITCH;
			glyph_w_q     <= RST_GLYPH_W;
			glyph_h_q     <= RST_GLYPH_H;
			bytes_glyph_q <= RST_BYTES_GLYPH;
			glyph_count_q <= RST_GLYPH_COUNT;
			map_en_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FB_BASE:     fb_base_q     <= cfg_data;
				REG_ROW_PITCH:   row_pitch_q   <= cfg_data[15:0];
				REG_GLYPH_W:     glyph_w_q     <= cfg_data[3:0];
				REG_GLYPH_H:     glyph_h_q     <= cfg_data[4:0];
				REG_BYTES_GLYPH: bytes_glyph_q <= cfg_data[4:0];
				REG_GLYPH_COUNT: glyph_count_q <= cfg_data[9:0];
				REG_MAP_ENABLE:  map_en_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= 4'd0;
			x_q         <= 3'd0;
			y_q         <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (gen) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (draw_go) begin
						state_q <= map_en_q ? ST_MAP : ST_GLY;
					end
				end
				ST_MAP:  state_q <= ST_GLY;
				ST_GLY:  state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_M4;
				ST_M4:   state_q <= ST_M5;
				ST_M5:   state_q <= ST_M6;
				ST_M6: begin
					k_q     <= 4'(MOD_K);
					x_q     <= 3'd0;
					y_q     <= 5'd0;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					k_q <= k_q - 4'd1;
					if (k_q == 4'd0) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (gen) begin
						if (char_end) begin
							state_q <= ST_IDLE;
						end else if (row_end) begin
							x_q     <= 3'd0;
							y_q     <= y_q + 5'd1;
							state_q <= ST_WAIT;
						end else begin
							x_q <= x_q + 3'd2;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			code_q <= char_code;
			cx_q   <= cell_x;
			cy_q   <= cell_y;
			fg_q   <= fg_color;
			bg_q   <= bg_color;
		end
		if (state_q == ST_GLY) begin
			glyph_q <= glyph_sel;
		end
		mul_q <= 32'(mul_a) * 32'(mul_b);
		case (state_q)
			ST_M2:  base_q <= mul_q[14:0];
			ST_M4:  offs_q <= mul_q;
			ST_M5:  offs_q <= offs_q + {mul_q[29:0], 2'b00};
			ST_M6: begin
				line_q <= fb_base_q + offs_q;
				pix_q  <= fb_base_q + offs_q;
			end
			ST_MOD: begin
				base_q <= mod_res[14:0];
				if (k_q == 4'd0) begin
					faddr_q <= FAW'(mod_res);
				end
			end
			default: ;
		endcase
		if (gen) begin
			addr_q         <= pix_q;
			first_q        <= bit_a ? fg_q : bg_q;
			second_q       <= sec_ok ? (bit_b ? fg_q : bg_q) : 32'd0;
			second_valid_q <= sec_ok;
			last_q         <= char_end;
			if (row_end) begin
				line_q  <= next_line;
				pix_q   <= next_line;
				faddr_q <= faddr_next;
			end else begin
				pix_q <= pix_q + 32'd8;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = addr_q;
	assign first_color   = first_q;
	assign second_color  = second_q;
	assign second_valid  = second_valid_q;
	assign last_in_char  = last_q;

endmodule

// ===== rtl/core/bgfr_checker.sv =====
// Port-level checker for the glyph renderer, bound to the top level.
`timescale 1ns / 1ps

module bgfr_checker
	import bgfr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  command,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pixel_address,
	input logic [31:0] first_color,
	input logic [31:0] second_color,
	input logic        second_valid,
	input logic        last_in_char
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_address)
			&& $stable(first_color) && $stable(second_color)
			&& $stable(last_in_char))
		else $error("result changed while stalled");

	a_busy_mid_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_in_char |-> !in_ready)
		else $error("input taken before character finished");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command != CMD_DRAW && !out_valid |=> !out_valid)
		else $error("load transfer produced a result");

	a_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !second_valid |-> second_color == 32'd0)
		else $error("invalid second pixel carries a color");

endmodule

bind bitmap_glyph_framebuffer_renderer_core bgfr_checker u_bgfr_checker (.*);
